// ----- hdl/sgs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_pkg
// Constants and the descriptor type of the scan gap segmenter.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int SEQ_W       = 10;
  localparam int COORD_W     = 16;
  localparam int GAP_W       = 16;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int MIN_GROUP   = 3;
  localparam int GAP_RESET   = 100;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = 3;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_USER_W  = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    seq_t group_seq;
    idx_t start_index;
    idx_t end_index;
    cnt_t point_count;
    logic wraps;
    logic scan_done;
    logic overflow;
  } desc_t;

endpackage

// ----- hdl/scan_gap_segmenter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_gap_segmenter
// Splits a lidar scan into groups of neighbouring points and emits one
// descriptor per kept group.
// ----------------------------------------------------------------------------
// Usage:
// Points enter on the s_ channel, one item per point: s_tdata holds x in the
// low half and y in the high half, s_tlast marks the final point of a scan.
// Group descriptors leave on the m_ channel; m_tlast marks the last descriptor
// of a scan and m_tuser carries the wrap and overflow flags.
// The gap register is written through cfg_we / cfg_wdata; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// Its square is registered in the cycle after the write. An item passes an
// input register, a product register holding the squared coordinate
// differences, and then the group logic, which pushes up to three descriptors
// into an eight-entry output queue. One item is taken every cycle while the
// queue has room for three descriptors; the queue drains one per cycle, so a
// stalled receiver holds the pipeline once six descriptors are waiting.
// Reset clears all scan state and queue, and sets the gap register to 100 mm.
// ----------------------------------------------------------------------------
module scan_gap_segmenter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sgs_pkg::GAP_W-1:0]       cfg_wdata,   // max_gap_mm
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sgs_pkg::IN_DATA_W-1:0]   s_tdata,     // point_x, point_y
  input  logic                            s_tlast,     // scan_last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // group_seq, start_index, end_index, point_count, zero fill
  output logic [sgs_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [sgs_pkg::OUT_USER_W-1:0]  m_tuser,     // wraps, overflow
  output logic                            m_tlast      // scan_done
);
  import sgs_pkg::*;

  localparam cnt_t MAX_CNT = CNT_W'(MAX_POINTS);
  localparam cnt_t MIN_CNT = CNT_W'(MIN_GROUP);

  // Configuration.
  logic [GAP_W-1:0] max_gap;
  logic [SQ_W-1:0]  gap_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= GAP_W'(GAP_RESET);
    end else if (cfg_we) begin
      max_gap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    gap_sq <= SQ_W'(max_gap) * SQ_W'(max_gap);
  end

  // Output queue bookkeeping.
  desc_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fifo_count;
  logic [FIFO_AW:0]   fifo_count_next;
  logic               adv;
  logic               pop;

  assign adv      = fifo_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 3);
  assign s_tready = adv;

  // Input side: previous and first point of the scan, tracked at acceptance.
  logic   in_acc;
  logic   at_start;
  coord_t in_prev_x, in_prev_y, in_first_x, in_first_y;
  coord_t x_in, y_in;

  assign in_acc = s_tvalid && s_tready;
  assign x_in   = s_tdata[COORD_W-1:0];
  assign y_in   = s_tdata[2*COORD_W-1:COORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (in_acc) begin
      at_start <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_prev_x <= x_in;
      in_prev_y <= y_in;
      if (at_start) begin
        in_first_x <= x_in;
        in_first_y <= y_in;
      end
    end
  end

  // Stage 1: input register.
  logic   s1_valid, s1_last;
  coord_t s1_x, s1_y, s1_px, s1_py, s1_fx, s1_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= s_tlast;
      s1_x    <= x_in;
      s1_y    <= y_in;
      s1_px   <= in_prev_x;
      s1_py   <= in_prev_y;
      s1_fx   <= at_start ? x_in : in_first_x;
      s1_fy   <= at_start ? y_in : in_first_y;
    end
  end

  // Stage 2: squared differences.
  logic signed [COORD_W:0]     dpx, dpy, dfx, dfy;
  logic signed [2*COORD_W+1:0] ppx, ppy, pfx, pfy;

  assign dpx = $signed({s1_x[COORD_W-1], s1_x}) - $signed({s1_px[COORD_W-1], s1_px});
  assign dpy = $signed({s1_y[COORD_W-1], s1_y}) - $signed({s1_py[COORD_W-1], s1_py});
  assign dfx = $signed({s1_x[COORD_W-1], s1_x}) - $signed({s1_fx[COORD_W-1], s1_fx});
  assign dfy = $signed({s1_y[COORD_W-1], s1_y}) - $signed({s1_fy[COORD_W-1], s1_fy});
  assign ppx = (2*COORD_W+2)'(dpx) * (2*COORD_W+2)'(dpx);
  assign ppy = (2*COORD_W+2)'(dpy) * (2*COORD_W+2)'(dpy);
  assign pfx = (2*COORD_W+2)'(dfx) * (2*COORD_W+2)'(dfx);
  assign pfy = (2*COORD_W+2)'(dfy) * (2*COORD_W+2)'(dfy);

  logic            s2_valid, s2_last;
  logic [SQ_W-1:0] s2_px2, s2_py2, s2_fx2, s2_fy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  // A 17-bit difference squared stays below 2^32, so the low bits are exact.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= s1_last;
      s2_px2  <= ppx[SQ_W-1:0];
      s2_py2  <= ppy[SQ_W-1:0];
      s2_fx2  <= pfx[SQ_W-1:0];
      s2_fy2  <= pfy[SQ_W-1:0];
    end
  end

  // Stage 3: group logic and scan state.
  cnt_t pidx, gcount, fgcount;
  idx_t gstart;
  seq_t gnum;
  logic fgclosed, ovf;

  cnt_t pidx_next, gcount_next, fgcount_next;
  idx_t gstart_next;
  seq_t gnum_next;
  logic fgclosed_next, ovf_next;

  logic            fire;
  logic            at_first, beyond, gap_hit, near_first;
  logic [SQ_W:0]   dist_prev, dist_first;
  idx_t            cur;
  logic [CNT_W:0]  total_raw;
  cnt_t            total;
  logic            pa, pb, pc;
  desc_t           da, db, dc;

  assign fire       = adv && s2_valid;
  assign dist_prev  = {1'b0, s2_px2} + {1'b0, s2_py2};
  assign dist_first = {1'b0, s2_fx2} + {1'b0, s2_fy2};

  always_comb begin
    at_first      = (pidx == '0);
    beyond        = (pidx >= MAX_CNT);
    gap_hit       = !at_first && (dist_prev > {1'b0, gap_sq});
    near_first    = (dist_first <= {1'b0, gap_sq});
    ovf_next      = ovf || beyond;
    cur           = beyond ? IDX_W'(MAX_POINTS - 1) : pidx[IDX_W-1:0];
    pidx_next     = beyond ? pidx : pidx + 1'b1;
    gcount_next   = gcount;
    fgcount_next  = fgcount;
    gstart_next   = gstart;
    gnum_next     = gnum;
    fgclosed_next = fgclosed;
    pa = 1'b0;
    pb = 1'b0;
    pc = 1'b0;
    da = '0;
    db = '0;
    dc = '0;
    da.overflow = ovf_next;
    db.overflow = ovf_next;
    dc.overflow = ovf_next;

    priority if (at_first) begin
      gstart_next = '0;
      gcount_next = CNT_W'(1);
    end else if (gap_hit) begin
      if (!fgclosed) begin
        fgclosed_next = 1'b1;
        fgcount_next  = gcount;
        gnum_next     = gnum + 1'b1;
      end else if (gcount >= MIN_CNT) begin
        pa             = 1'b1;
        da.group_seq   = gnum;
        da.start_index = gstart;
        da.end_index   = pidx[IDX_W-1:0] - 1'b1;
        da.point_count = gcount;
        gnum_next      = gnum + 1'b1;
      end
      gstart_next = cur;
      gcount_next = CNT_W'(1);
    end else begin
      gcount_next = (gcount >= MAX_CNT) ? MAX_CNT : gcount + 1'b1;
    end

    total_raw = {1'b0, gcount_next} + {1'b0, fgcount_next};
    total     = (total_raw > {1'b0, MAX_CNT}) ? MAX_CNT : total_raw[CNT_W-1:0];

    if (s2_last) begin
      priority if (!fgclosed_next) begin
        pb             = gcount_next >= MIN_CNT;
        db.end_index   = cur;
        db.point_count = gcount_next;
      end else if (near_first) begin
        // The last group runs on into the first one across the scan seam.
        pb             = total >= MIN_CNT;
        db.group_seq   = gnum_next;
        db.start_index = gstart_next;
        db.end_index   = fgcount_next[IDX_W-1:0] - 1'b1;
        db.point_count = total;
        db.wraps       = 1'b1;
      end else begin
        pb             = 1'b1;
        db.end_index   = fgcount_next[IDX_W-1:0] - 1'b1;
        db.point_count = fgcount_next;
        pc             = gcount_next >= MIN_CNT;
        dc.group_seq   = gnum_next;
        dc.start_index = gstart_next;
        dc.end_index   = cur;
        dc.point_count = gcount_next;
      end
      dc.scan_done = pc;
      db.scan_done = pb && !pc;
      da.scan_done = pa && !pb && !pc;
      pidx_next     = '0;
      gcount_next   = '0;
      fgcount_next  = '0;
      gstart_next   = '0;
      gnum_next     = '0;
      fgclosed_next = 1'b0;
      ovf_next      = 1'b0;
    end

    if (!fire) begin
      pa = 1'b0;
      pb = 1'b0;
      pc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pidx     <= '0;
      gcount   <= '0;
      fgcount  <= '0;
      gstart   <= '0;
      gnum     <= '0;
      fgclosed <= 1'b0;
      ovf      <= 1'b0;
    end else if (fire) begin
      pidx     <= pidx_next;
      gcount   <= gcount_next;
      fgcount  <= fgcount_next;
      gstart   <= gstart_next;
      gnum     <= gnum_next;
      fgclosed <= fgclosed_next;
      ovf      <= ovf_next;
    end
  end

  // Output queue: up to three descriptors written in order each cycle.
  logic [FIFO_AW-1:0] idx_b, idx_c;
  logic [1:0]         npush;

  assign idx_b = wr_ptr + FIFO_AW'(pa);
  assign idx_c = idx_b + FIFO_AW'(pb);
  assign npush = 2'(pa) + 2'(pb) + 2'(pc);
  assign pop   = m_tvalid && m_tready;
  assign fifo_count_next = fifo_count + (FIFO_AW + 1)'(npush) - (FIFO_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (pa) begin
      fifo_mem[wr_ptr] <= da;
    end
    if (pb) begin
      fifo_mem[idx_b] <= db;
    end
    if (pc) begin
      fifo_mem[idx_c] <= dc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_AW'(npush);
      rd_ptr     <= rd_ptr + FIFO_AW'(pop);
      fifo_count <= fifo_count_next;
    end
  end

  desc_t head;

  assign head     = fifo_mem[rd_ptr];
  assign m_tvalid = fifo_count != '0;
  assign m_tdata  = {(OUT_DATA_W - SEQ_W - 2 * IDX_W - CNT_W)'(0),
                     head.point_count, head.end_index, head.start_index, head.group_seq};
  assign m_tuser  = {head.overflow, head.wraps};
  assign m_tlast  = head.scan_done;

  // Checks.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count_next <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("output queue overrun");

  a_index_sat: assert property (@(posedge clk) disable iff (rst)
    pidx <= MAX_CNT)
    else $error("point index beyond saturation");

  a_scan_clear: assert property (@(posedge clk) disable iff (rst)
    fire && s2_last |=> pidx == '0 && !fgclosed && !ovf)
    else $error("scan state not cleared after final point");

  a_open_group: assert property (@(posedge clk) disable iff (rst)
    pidx != '0 |-> gcount != '0)
    else $error("open group empty inside a scan");

endmodule

// ----- verif/sgs_descriptor_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_descriptor_checker
// Watches the point and descriptor channels of the scan gap segmenter. Every
// accepted point is run through a cycle-free model of the gap segmentation,
// and the descriptors it produces are queued. Every accepted descriptor is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module sgs_descriptor_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sgs_pkg::GAP_W-1:0]      cfg_wdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [sgs_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [sgs_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [sgs_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           m_tlast,
  output int                             mismatches,
  output int                             groups_due
);
  import sgs_pkg::*;

  localparam int START_LSB = SEQ_W;
  localparam int END_LSB   = SEQ_W + IDX_W;
  localparam int COUNT_LSB = SEQ_W + 2 * IDX_W;
  localparam cnt_t POINT_CAP = CNT_W'(MAX_POINTS);
  localparam cnt_t GROUP_MIN = CNT_W'(MIN_GROUP);

  logic [GAP_W-1:0] gap_limit;
  logic [CNT_W-1:0] points_seen;
  coord_t           prior_x, prior_y, head_x, head_y;
  idx_t             run_start;
  cnt_t             run_count;
  seq_t             run_seq;
  cnt_t             head_count;
  logic             head_closed;
  logic             overran;
  desc_t            due_groups[$];

  function automatic longint dist_sq(input coord_t ax, input coord_t ay,
                                     input coord_t bx, input coord_t by);
    longint dx, dy;
    dx = longint'($signed(ax)) - longint'($signed(bx));
    dy = longint'($signed(ay)) - longint'($signed(by));
    return dx * dx + dy * dy;
  endfunction

  function automatic int clip_count(input int c);
    return (c > MAX_POINTS) ? MAX_POINTS : c;
  endfunction

  function automatic desc_t make_group(input seq_t seq, input idx_t first,
                                       input idx_t final_idx, input cnt_t cnt,
                                       input logic wrapped);
    desc_t d;
    d.group_seq   = seq;
    d.start_index = first;
    d.end_index   = final_idx;
    d.point_count = cnt;
    d.wraps       = wrapped;
    d.scan_done   = 1'b0;
    d.overflow    = overran;
    return d;
  endfunction

  task automatic clear_scan_state();
    points_seen = '0;
    prior_x     = '0;
    prior_y     = '0;
    head_x      = '0;
    head_y      = '0;
    run_start   = '0;
    run_count   = '0;
    run_seq     = '0;
    head_count  = '0;
    head_closed = 1'b0;
    overran     = 1'b0;
  endtask

  // Works out the descriptors caused by one point and queues them in order.
  task automatic segment_point(input coord_t px, input coord_t py, input logic last);
    desc_t  found[3];
    int     n;
    int     total;
    idx_t   here;
    longint reach_sq;
    n = 0;
    reach_sq = longint'(gap_limit) * longint'(gap_limit);
    if (points_seen >= POINT_CAP) begin
      overran = 1'b1;
      here = idx_t'(MAX_POINTS - 1);
    end else begin
      here = idx_t'(points_seen);
    end

    if (points_seen == '0) begin
      head_x    = px;
      head_y    = py;
      run_start = '0;
      run_count = cnt_t'(1);
    end else if (dist_sq(prior_x, prior_y, px, py) > reach_sq) begin
      // The first group is never emitted here: it waits for the scan end.
      if (!head_closed) begin
        head_closed = 1'b1;
        head_count  = run_count;
        run_seq     = run_seq + 1'b1;
      end else if (run_count >= GROUP_MIN) begin
        found[n] = make_group(run_seq, run_start, idx_t'(points_seen - 1), run_count,
                              1'b0);
        n = n + 1;
        run_seq = run_seq + 1'b1;
      end
      run_start = here;
      run_count = cnt_t'(1);
    end else begin
      run_count = cnt_t'(clip_count(int'(run_count) + 1));
    end
    prior_x = px;
    prior_y = py;
    if (points_seen < POINT_CAP) points_seen = points_seen + 1'b1;

    if (last) begin
      if (!head_closed) begin
        if (run_count >= GROUP_MIN) begin
          found[n] = make_group('0, '0, here, run_count, 1'b0);
          n = n + 1;
        end
      end else if (dist_sq(head_x, head_y, px, py) <= reach_sq) begin
        // The last group closes the ring and absorbs the first group.
        total = clip_count(int'(run_count) + int'(head_count));
        if (total >= MIN_GROUP) begin
          found[n] = make_group(run_seq, run_start, idx_t'(head_count - 1),
                                cnt_t'(total), 1'b1);
          n = n + 1;
        end
      end else begin
        found[n] = make_group('0, '0, idx_t'(head_count - 1), head_count, 1'b0);
        n = n + 1;
        if (run_count >= GROUP_MIN) begin
          found[n] = make_group(run_seq, run_start, here, run_count, 1'b0);
          n = n + 1;
        end
      end
      if (n > 0) found[n-1].scan_done = 1'b1;
      clear_scan_state();
    end

    for (int i = 0; i < n; i++) due_groups.insert(due_groups.size(), found[i]);
  endtask

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_descriptor();
    desc_t want;
    if (due_groups.size() == 0) begin
      $error("descriptor seq %0d arrived with no group due", m_tdata[SEQ_W-1:0]);
      mismatches++;
    end else begin
      want = due_groups.pop_front();
      compare_field("group_seq", int'(want.group_seq), int'(m_tdata[SEQ_W-1:0]));
      compare_field("start_index", int'(want.start_index),
                    int'(m_tdata[START_LSB +: IDX_W]));
      compare_field("end_index", int'(want.end_index), int'(m_tdata[END_LSB +: IDX_W]));
      compare_field("point_count", int'(want.point_count),
                    int'(m_tdata[COUNT_LSB +: CNT_W]));
      compare_field("wraps", int'(want.wraps), int'(m_tuser[0]));
      compare_field("scan_done", int'(want.scan_done), int'(m_tlast));
      compare_field("overflow", int'(want.overflow), int'(m_tuser[1]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gap_limit = GAP_W'(GAP_RESET);
      clear_scan_state();
      due_groups.delete();
    end else begin
      if (cfg_we) gap_limit = cfg_wdata;
      if (m_tvalid && m_tready) check_descriptor();
      if (s_tvalid && s_tready) segment_point(s_tdata[15:0], s_tdata[31:16], s_tlast);
    end
    groups_due = due_groups.size();
  end

endmodule

// ----- verif/scan_gap_segmenter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_gap_segmenter_test
// Feeds lidar scans into the scan gap segmenter: a few hand-built scans for
// the boundary cases, then random walks with gaps, wrap-arounds and short
// broken scans, under several gap settings and with random stalls on both
// channels. The checker beside the block predicts and compares every
// descriptor.
// ----------------------------------------------------------------------------
module scan_gap_segmenter_test;
  import sgs_pkg::*;

  localparam int          HOLD_CYCLES  = 150;
  localparam int          DRAIN_CYCLES = 8;
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [GAP_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  int mismatches;
  int groups_due;
  int points_sent = 0;
  int gap_setting = GAP_RESET;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks   = 0;
  int holds_done  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  scan_gap_segmenter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sgs_descriptor_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .mismatches(mismatches),
    .groups_due(groups_due)
  );

  // Descriptor sink: random back-pressure, plus a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("scan_gap_segmenter_test: errors");
    $finish;
  end

  // Offers one point and returns just after the edge at which it is taken.
  // Ready is read at the falling edge, where it is settled for the next edge.
  task automatic drive_point(input int x, input int y, input logic last);
    logic took;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {coord_t'(y), coord_t'(x)};
    s_tlast  <= last;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    points_sent++;
  endtask

  task automatic await_descriptors();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (groups_due != 0);
    // Points that make no descriptor may still be in the pipeline.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_gap(input int gap_mm);
    await_descriptors();
    cfg_we    <= 1'b1;
    cfg_wdata <= GAP_W'(gap_mm);
    @(posedge clk);
    cfg_we <= 1'b0;
    gap_setting = gap_mm;
    repeat (2) @(posedge clk);
  endtask

  // A random walk: steps stay within the gap, but jump_pct percent of them jump
  // anywhere. When close_ring is set the final point lands near the first one.
  task automatic walk_scan(input int len, input int jump_pct, input bit close_ring);
    coord_t x, y, x0, y0;
    int     reach;
    reach = gap_setting / 2;
    if (reach > 16000) reach = 16000;
    x  = coord_t'($urandom);
    y  = coord_t'($urandom);
    x0 = x;
    y0 = y;
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if ($urandom_range(99) < jump_pct) begin
          x = coord_t'($urandom);
          y = coord_t'($urandom);
        end else begin
          x = x + coord_t'(int'($urandom_range(2 * reach)) - reach);
          y = y + coord_t'(int'($urandom_range(2 * reach)) - reach);
        end
        if (close_ring && i == len - 1) begin
          x = x0 + coord_t'($urandom_range(reach));
          y = y0;
        end
      end
      drive_point(int'(x), int'(y), i == len - 1);
    end
  endtask

  task automatic random_scans(input int quota);
    int goal, len, kind;
    goal = points_sent + quota;
    while (points_sent < goal) begin
      kind = $urandom_range(9);
      // One scan in ten is a stub of one or two points.
      if (kind == 0) len = $urandom_range(1, 2);
      else len = $urandom_range(4, 16);
      walk_scan(len, (kind == 1) ? 60 : 20, $urandom_range(2) == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Gap register still at its reset value of 100 mm.
    drive_point(0, 0, 1'b1);
    drive_point(0, 0, 1'b0);
    drive_point(60, 80, 1'b0);
    drive_point(120, 160, 1'b1);
    // Small first group, a lone point, a kept group and a short last group.
    drive_point(0, 0, 1'b0);
    drive_point(0, 50, 1'b0);
    drive_point(0, 151, 1'b0);
    drive_point(1000, 0, 1'b0);
    drive_point(1010, 0, 1'b0);
    drive_point(1020, 0, 1'b0);
    drive_point(3000, 0, 1'b0);
    drive_point(3010, 0, 1'b1);
    // The last group meets the first one again.
    drive_point(0, 0, 1'b0);
    drive_point(500, 0, 1'b0);
    drive_point(510, 0, 1'b0);
    drive_point(520, 0, 1'b0);
    drive_point(200, 0, 1'b0);
    drive_point(100, 0, 1'b0);
    drive_point(50, 0, 1'b1);

    set_gap(65535);
    drive_point(-32768, -32768, 1'b0);
    drive_point(32767, 32767, 1'b0);
    drive_point(32767, -32768, 1'b0);
    drive_point(-32768, 32767, 1'b1);

    set_gap(0);
    drive_point(-1, -1, 1'b0);
    drive_point(-1, -1, 1'b0);
    drive_point(-1, -1, 1'b1);

    set_gap(100);
    tx_idle_pct = 12;
    rx_idle_pct = 72;
    random_scans(15);
    hold_asks++;
    random_scans(60);

    set_gap($urandom_range(1, 3000));
    tx_idle_pct = 72;
    rx_idle_pct = 12;
    random_scans(20);
    await_descriptors();
    random_scans(20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_gap(20);
    random_scans(25);

    await_descriptors();
    if (mismatches == 0 && groups_due == 0) begin
      $display("scan_gap_segmenter_test: clean");
    end else begin
      $display("scan_gap_segmenter_test: errors");
    end
    $finish;
  end

endmodule
